[rtl/zmtp2_frame_encoder_core_macros.svh]
// Assertion macros shared by the frame encoder RTL.
`ifndef ZMTP2_FRAME_ENCODER_CORE_MACROS_SVH
`define ZMTP2_FRAME_ENCODER_CORE_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ZFE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ZFE_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define ZFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/zfe_pkg.sv]
// Shared types and constants of the frame encoder.
`default_nettype none

package zfe_pkg;

    localparam logic OP_START = 1'b0;
    localparam logic OP_BODY  = 1'b1;

    localparam logic [7:0] LONG_FLAG  = 8'h02;
    localparam logic [7:0] SHORT_FLAG = 8'h00;
    localparam int         SHORT_MAX  = 255;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam int              HDR_IDX_W      = 4;
    localparam logic [HDR_IDX_W-1:0] HDR_FIRST      = 4'd0;
    localparam logic [HDR_IDX_W-1:0] HDR_SHORT_LAST = 4'd1;
    localparam logic [HDR_IDX_W-1:0] HDR_LONG_LAST  = 4'd8;

    typedef enum logic [1:0] {
        PH_IDLE = 2'b01,
        PH_BODY = 2'b10
    } phase_t;

    typedef enum logic [1:0] {
        K_HDR  = 2'd0,
        K_BODY = 2'd1,
        K_ERR  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t kind;
        logic  long_len;
        logic  zero_len;
        logic  last;
    } cmd_t;

endpackage

`default_nettype wire

[rtl/zfe_front.sv]
// Front end: accepts items, tracks frame phase and byte count, issues commands.
`default_nettype none
`include "zmtp2_frame_encoder_core_macros.svh"

module zfe_front #(
    parameter int LENGTH_BITS = 32
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   operation,
    input  wire logic [31:0]            message_length,
    input  wire logic [7:0]             data_byte,
    output logic                        push,
    output zfe_pkg::cmd_t               push_cmd,
    output logic [LENGTH_BITS-1:0]      push_payload,
    input  wire logic                   queue_full
);

    zfe_pkg::phase_t        phase_reg, phase_next;
    logic [LENGTH_BITS-1:0] rem_reg, rem_next;
    logic [LENGTH_BITS-1:0] len;
    logic                   accept;
    logic                   rem_last;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept;
    assign len      = LENGTH_BITS'(message_length);
    assign rem_last = (rem_reg == LENGTH_BITS'(1));

    always_comb
    begin
        phase_next            = phase_reg;
        rem_next              = rem_reg;
        push_cmd.kind         = zfe_pkg::K_ERR;
        push_cmd.long_len     = 1'b0;
        push_cmd.zero_len     = 1'b0;
        push_cmd.last         = 1'b0;
        push_payload          = '0;
        if (operation == zfe_pkg::OP_START)
        begin
            if (phase_reg == zfe_pkg::PH_IDLE)
            begin
                push_cmd.kind     = zfe_pkg::K_HDR;
                push_cmd.long_len = (len > LENGTH_BITS'(zfe_pkg::SHORT_MAX));
                push_cmd.zero_len = (len == '0);
                push_payload      = len;
                if (accept && (len != '0))
                begin
                    phase_next = zfe_pkg::PH_BODY;
                    rem_next   = len;
                end
            end
        end
        else
        begin
            if (phase_reg == zfe_pkg::PH_BODY)
            begin
                push_cmd.kind = zfe_pkg::K_BODY;
                push_cmd.last = rem_last;
                push_payload  = LENGTH_BITS'(data_byte);
                if (accept)
                begin
                    rem_next = rem_reg - LENGTH_BITS'(1);
                    if (rem_last)
                    begin
                        phase_next = zfe_pkg::PH_IDLE;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= zfe_pkg::PH_IDLE;
            rem_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            rem_reg   <= rem_next;
        end
    end

    `ZFE_ASSERT_IMPLY(a_body_has_bytes, phase_reg == zfe_pkg::PH_BODY, rem_reg != '0,
        "open frame with zero remaining bytes")
    `ZFE_ASSERT_NEXT(a_idle_rem_zero,
        accept && (phase_reg == zfe_pkg::PH_BODY) && (operation == zfe_pkg::OP_BODY) && rem_last,
        (phase_reg == zfe_pkg::PH_IDLE) && (rem_reg == '0),
        "frame did not close on its last byte")

endmodule

`default_nettype wire

[rtl/zfe_queue.sv]
// Command queue between the front end and the byte emitter.
`default_nettype none
`include "zmtp2_frame_encoder_core_macros.svh"

module zfe_queue #(
    parameter int WIDTH = 38
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    output logic                  rd_valid,
    output logic [WIDTH-1:0]      rd_data,
    input  wire logic             rd_en
);

    logic [WIDTH-1:0]              entry_reg [zfe_pkg::QUEUE_DEPTH];
    logic [zfe_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [zfe_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [zfe_pkg::QCNT_W-1:0]    count_reg, count_next;

    assign full     = (count_reg == zfe_pkg::QCNT_W'(zfe_pkg::QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = wr_ptr_reg + zfe_pkg::QPTR_W'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = rd_ptr_reg + zfe_pkg::QPTR_W'(1);
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + zfe_pkg::QCNT_W'(1);
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - zfe_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `ZFE_ASSERT_ALWAYS(a_count_bound, count_reg <= zfe_pkg::QCNT_W'(zfe_pkg::QUEUE_DEPTH),
        "queue count past depth")
    `ZFE_ASSERT_IMPLY(a_ptr_track, count_reg == '0, wr_ptr_reg == rd_ptr_reg,
        "queue pointers disagree with count")

endmodule

`default_nettype wire

[rtl/zfe_back.sv]
// Back end: expands commands into framed bytes behind an output register.
`default_nettype none
`include "zmtp2_frame_encoder_core_macros.svh"

module zfe_back #(
    parameter int LENGTH_BITS = 32
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   head_valid,
    input  wire zfe_pkg::cmd_t          head_cmd,
    input  wire logic [LENGTH_BITS-1:0] head_payload,
    output logic                        pop,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [7:0]                  out_byte,
    output logic                        frame_end,
    output logic                        error
);

    logic [zfe_pkg::HDR_IDX_W-1:0] idx_reg, idx_next;
    logic                          out_valid_reg, out_valid_next;
    logic [7:0]                    out_byte_reg, byte_sel;
    logic                          frame_end_reg, end_sel;
    logic                          error_reg, err_sel;
    logic [7:0][7:0]               len_bytes;
    logic [zfe_pkg::HDR_IDX_W-1:0] last_idx;
    logic [2:0]                    byte_pos;
    logic                          load;
    logic                          step;
    logic                          done;

    assign len_bytes = 64'(head_payload);
    assign last_idx  = head_cmd.long_len ? zfe_pkg::HDR_LONG_LAST : zfe_pkg::HDR_SHORT_LAST;
    assign byte_pos  = 3'(zfe_pkg::HDR_LONG_LAST - idx_reg);
    assign load      = !out_valid_reg || out_ready;
    assign step      = load && head_valid;
    assign pop       = step && done;

    always_comb
    begin
        byte_sel = 8'h00;
        end_sel  = 1'b0;
        err_sel  = 1'b0;
        done     = 1'b1;
        case (head_cmd.kind)
            zfe_pkg::K_HDR:
            begin
                done    = (idx_reg == last_idx);
                end_sel = done && head_cmd.zero_len;
                if (idx_reg == zfe_pkg::HDR_FIRST)
                begin
                    byte_sel = head_cmd.long_len ? zfe_pkg::LONG_FLAG : zfe_pkg::SHORT_FLAG;
                end
                else if (head_cmd.long_len)
                begin
                    byte_sel = len_bytes[byte_pos];
                end
                else
                begin
                    byte_sel = head_payload[7:0];
                end
            end
            zfe_pkg::K_BODY:
            begin
                byte_sel = head_payload[7:0];
                end_sel  = head_cmd.last;
            end
            zfe_pkg::K_ERR:
            begin
                err_sel = 1'b1;
            end
            default:
            begin
                err_sel = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (step)
        begin
            idx_next = done ? zfe_pkg::HDR_FIRST : idx_reg + zfe_pkg::HDR_IDX_W'(1);
        end
        if (load)
        begin
            out_valid_next = head_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= zfe_pkg::HDR_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_byte_reg  <= byte_sel;
            frame_end_reg <= end_sel;
            error_reg     <= err_sel;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign frame_end = frame_end_reg;
    assign error     = error_reg;

    `ZFE_ASSERT_ALWAYS(a_idx_bound, idx_reg <= zfe_pkg::HDR_LONG_LAST,
        "header index past last byte")
    `ZFE_ASSERT_IMPLY(a_err_clean, out_valid_reg && error_reg,
        (out_byte_reg == 8'h00) && !frame_end_reg, "error result carries data")

endmodule

`default_nettype wire

[rtl/zmtp2_frame_encoder_core.sv]
// Top level of the ZMTP 2.0 frame encoder.
// Start items (operation 0) open a frame and produce a header of two bytes (flags, one-byte
// length) or nine bytes (flags 0x02, eight-byte big-endian length) when the length exceeds
// 255 (zero opens none, ending on its header); body items (operation 1) pass one byte each
// and the frame's final byte carries frame_end. A start inside an open frame or a body byte
// outside one gives a single error result. The front end classifies each item in the cycle it
// is accepted and pushes a command into a four-entry queue; the back end drains one byte per
// cycle into a registered output, and body bytes sustain one item per clock, while out_ready
// allows. A start item holds the output for its header bytes, and input stalls only when the
// queue fills behind it. An item's first result passes the queue, then the output register.
`default_nettype none

module zmtp2_frame_encoder_core #(
    parameter int LENGTH_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        operation,
    input  wire logic [31:0] message_length,
    input  wire logic [7:0]  data_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic             frame_end,
    output logic             error
);

    localparam int CmdW   = $bits(zfe_pkg::cmd_t);
    localparam int EntryW = CmdW + LENGTH_BITS;

    logic                   push;
    zfe_pkg::cmd_t          push_cmd;
    logic [LENGTH_BITS-1:0] push_payload;
    logic                   queue_full;
    logic                   head_valid;
    logic [EntryW-1:0]      head_entry;
    zfe_pkg::cmd_t          head_cmd;
    logic [LENGTH_BITS-1:0] head_payload;
    logic                   pop;

    assign head_cmd     = zfe_pkg::cmd_t'(head_entry[EntryW-1:LENGTH_BITS]);
    assign head_payload = head_entry[LENGTH_BITS-1:0];

    zfe_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .message_length(message_length),
        .data_byte     (data_byte),
        .push          (push),
        .push_cmd      (push_cmd),
        .push_payload  (push_payload),
        .queue_full    (queue_full)
    );

    zfe_queue #(
        .WIDTH(EntryW)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data ({push_cmd, push_payload}),
        .full    (queue_full),
        .rd_valid(head_valid),
        .rd_data (head_entry),
        .rd_en   (pop)
    );

    zfe_back #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_cmd    (head_cmd),
        .head_payload(head_payload),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .frame_end   (frame_end),
        .error       (error)
    );

endmodule

`default_nettype wire
